>>> hdl/pir_pkg.sv
// Package: shared types, constants and register indexes for the PIR presence tracker.
package pir_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 8;
   localparam int WIN_MIN_WIDTH  = 8;
   localparam int WIN_LIM_WIDTH  = 24;

   localparam logic [TIME_WIDTH-1:0] HOLD_MS         = TIME_WIDTH'(5000);
   localparam logic [TIME_WIDTH-1:0] START_WINDOW_MS = TIME_WIDTH'(180 * 1000);
   localparam logic [WIN_LIM_WIDTH-WIN_MIN_WIDTH-1:0] MS_PER_MIN =
      (WIN_LIM_WIDTH-WIN_MIN_WIDTH)'(60 * 1000);
   localparam logic [WIN_LIM_WIDTH-1:0] MS_PER_S_LESS1 = WIN_LIM_WIDTH'(1000 - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ESTABLISHED = COUNT_WIDTH'(2);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SENSOR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REPORT_ENABLE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WINDOW_MIN    = 2'd2;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  pir_level;
   } req_type;

   typedef struct packed {
      logic                   motion_state;
      logic                   report_valid;
      logic                   report_level;
      logic [COUNT_WIDTH-1:0] presence_count;
      logic                   episode_start;
   } rsp_type;

endpackage

>>> hdl/pir_core.sv
// Configuration registers, tracker state and the per-poll update logic.
module pir_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [pir_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [pir_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  logic                                  poll_fire,
   input  pir_pkg::req_type                      poll,
   output pir_pkg::rsp_type                      result
);
   import pir_pkg::*;

   logic                     sensor_enable_ff;
   logic                     report_enable_ff;
   logic [WIN_MIN_WIDTH-1:0] window_min_ff;

   logic                   motion_held_ff,  motion_held_in;
   logic [TIME_WIDTH-1:0]  last_sample_ff,  last_sample_in;
   logic [TIME_WIDTH-1:0]  ep_first_ff,     ep_first_in;
   logic [TIME_WIDTH-1:0]  ep_last_ff,      ep_last_in;
   logic [COUNT_WIDTH-1:0] ep_count_ff,     ep_count_in;

   logic [TIME_WIDTH-1:0]    since_sample, since_first, since_last;
   logic [WIN_LIM_WIDTH-1:0] win_limit;
   logic                     sampled, extend;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_enable_ff <= 1'b1;
         report_enable_ff <= 1'b0;
         window_min_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_ENABLE: sensor_enable_ff <= csr_wdata[0];
            CSR_REPORT_ENABLE: report_enable_ff <= csr_wdata[0];
            CSR_WINDOW_MIN:    window_min_ff    <= csr_wdata[WIN_MIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Whole-second truncation folded into the limits:
   // secs < 180 <=> ms < 180000; secs <= W*60 <=> ms <= W*60000 + 999.
   assign since_sample = poll.now_ms - last_sample_ff;
   assign since_first  = poll.now_ms - ep_first_ff;
   assign since_last   = poll.now_ms - ep_last_ff;
   assign win_limit    = WIN_LIM_WIDTH'(window_min_ff * MS_PER_MIN) + MS_PER_S_LESS1;
   assign sampled      = sensor_enable_ff && (!motion_held_ff || since_sample >= HOLD_MS);
   assign extend       = (since_first < START_WINDOW_MS) ||
                         (since_last <= TIME_WIDTH'(win_limit) &&
                          ep_count_ff > COUNT_ESTABLISHED);

   always_comb begin
      motion_held_in = motion_held_ff;
      last_sample_in = last_sample_ff;
      ep_first_in    = ep_first_ff;
      ep_last_in     = ep_last_ff;
      ep_count_in    = ep_count_ff;
      result         = '0;
      if (sampled) begin
         if (motion_held_ff && !poll.pir_level && report_enable_ff) begin
            result.report_valid = 1'b1;
         end
         motion_held_in = poll.pir_level;
         if (poll.pir_level) begin
            last_sample_in = poll.now_ms;
            ep_last_in     = poll.now_ms;
            if (report_enable_ff) begin
               result.report_valid = 1'b1;
               result.report_level = 1'b1;
            end
            if (extend) begin
               if (ep_count_ff != COUNT_MAX) begin
                  ep_count_in = ep_count_ff + COUNT_ONE;
               end
            end else begin
               ep_first_in          = poll.now_ms;
               ep_count_in          = COUNT_ONE;
               result.episode_start = 1'b1;
            end
         end
      end
      result.motion_state   = motion_held_in;
      result.presence_count = ep_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_held_ff <= 1'b0;
         last_sample_ff <= '0;
         ep_first_ff    <= '0;
         ep_last_ff     <= '0;
         ep_count_ff    <= '0;
      end else if (poll_fire) begin
         motion_held_ff <= motion_held_in;
         last_sample_ff <= last_sample_in;
         ep_first_ff    <= ep_first_in;
         ep_last_ff     <= ep_last_in;
         ep_count_ff    <= ep_count_in;
      end
   end

endmodule

>>> hdl/pir_presence_tracker_top.sv
// Top level of the PIR presence tracker: core update logic plus a two-entry result buffer.
// A poll's result is registered into the output register, or into the skid entry if the sink stalls.
// Throughput: one poll per cycle while the skid entry is empty; the state update is a combinational compare/add path.
// req_ready is registered-only (skid empty), so a stalled rsp_ side never blocks req_ combinationally.
// Reset (synchronous, active high): sensor enabled, reports off, window 0 min, all state zero,
// both result entries empty.
module pir_presence_tracker_top (
   input  logic                               clock,
   input  logic                               reset,
   // poll input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pir_pkg::req_type                   req_payload,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pir_pkg::rsp_type                   rsp_payload,
   // configuration writes
   input  logic                               csr_we,
   input  logic [pir_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [pir_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import pir_pkg::*;

   rsp_type core_result;
   rsp_type out_ff,  skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    in_xfer, out_xfer;

   // A poll transfer updates state in the same edge it is taken.
   assign in_xfer  = req_valid && req_ready;
   assign out_xfer = out_valid_ff && rsp_ready;

   pir_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .poll_fire (in_xfer),
      .poll      (req_payload),
      .result    (core_result)
   );

   // Output register plus skid entry. The skid entry fills only when a
   // result arrives while the output register is held by a stalled sink.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_xfer) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_xfer) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_xfer) begin
            out_ff <= skid_ff;
         end
      end else if (in_xfer) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_ff <= core_result;
         end else begin
            out_ff <= core_result;
         end
      end
   end

   assign req_ready   = !skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // The skid entry never holds a result while the output register is empty.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A transfer into a stalled, occupied output must land in the skid entry.
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("result lost on stalled output");

   // A new episode always restarts the count at one with motion held.
   a_episode_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.episode_start) |->
         (rsp_payload.presence_count == COUNT_ONE && rsp_payload.motion_state))
      else $error("episode start without count one and motion");

   // A reported level is only ever nonzero on a valid report with motion held.
   a_report_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.report_level) |->
         (rsp_payload.report_valid && rsp_payload.motion_state))
      else $error("report level set without a valid motion report");

endmodule
